@@ rtl/dmf_pkg.sv @@
// shared types and constants of the max-flow engine
`timescale 1ns / 1ps
`default_nettype none
package dmf_pkg;
	localparam int MAX_NODES = 64;
	localparam int MAX_ARCS  = 512;
	localparam int NODE_W    = 6;
	localparam int ARC_W     = 9;
	localparam int PTR_W     = 10;
	localparam int CAP_W     = 32;
	localparam int FLOW_W    = 40;
	localparam int LVL_W     = 7;
	localparam int CNT_W     = 7;
	localparam int NCNT_W    = 7;

	localparam logic [PTR_W-1:0] EMPTY_ARC = PTR_W'(MAX_ARCS);

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_SAME  = 2'd3;

	typedef enum logic [30:0] {
		S_IDLE     = 31'h00000001,
		S_CHECK    = 31'h00000002,
		S_AE0      = 31'h00000004,
		S_AE1      = 31'h00000008,
		S_AE2      = 31'h00000010,
		S_AE3      = 31'h00000020,
		S_CLR      = 31'h00000040,
		S_LP_INIT  = 31'h00000080,
		S_LP_DEQ   = 31'h00000100,
		S_LP_DEQ2  = 31'h00000200,
		S_LP_FIRST = 31'h00000400,
		S_LP_ARC   = 31'h00000800,
		S_LP_ARC2  = 31'h00001000,
		S_AU_START = 31'h00002000,
		S_AU_TOP   = 31'h00004000,
		S_AU_CUR   = 31'h00008000,
		S_AU_SCAN  = 31'h00010000,
		S_AU_SCAN2 = 31'h00020000,
		S_AU_SCAN3 = 31'h00040000,
		S_AU_END   = 31'h00080000,
		S_AU_POP   = 31'h00100000,
		S_AU_POP2  = 31'h00200000,
		S_AP_RD    = 31'h00400000,
		S_AP_RD2   = 31'h00800000,
		S_AP_RD3   = 31'h01000000,
		S_AP_UP    = 31'h02000000,
		S_AP_UP2   = 31'h04000000,
		S_AP_UP3   = 31'h08000000,
		S_AP_UP4   = 31'h10000000,
		S_AP_DONE  = 31'h20000000,
		S_DONE     = 31'h40000000
	} op_t;

	typedef struct packed {
		logic       chk_fail;
		logic [1:0] req;
		logic       deq_more;
		logic       sink_found;
		logic       a_empty;
		logic       at_sink;
		logic       found;
		logic       push_ok;
		logic       depth_zero;
		logic       i_more;
		logic       out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

@@ rtl/dmf_ctrl.sv @@
// sequencer of the max-flow engine
`timescale 1ns / 1ps
`default_nettype none
module dmf_ctrl import dmf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire dp_stat_t stat,
	output op_t           op
);
	op_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.chk_fail) state_d = S_DONE;
				else if (stat.req == REQ_ADD) state_d = S_AE0;
				else if (stat.req == REQ_RUN) state_d = S_LP_INIT;
				else if (stat.req == REQ_CLEAR) state_d = S_CLR;
				else state_d = S_DONE;
			end
			S_AE0:      state_d = S_AE1;
			S_AE1:      state_d = S_AE2;
			S_AE2:      state_d = S_AE3;
			S_AE3:      state_d = S_DONE;
			S_CLR:      state_d = S_DONE;
			S_LP_INIT:  state_d = S_LP_DEQ;
			S_LP_DEQ: begin
				if (stat.deq_more) state_d = S_LP_DEQ2;
				else if (stat.sink_found) state_d = S_AU_START;
				else state_d = S_DONE;
			end
			S_LP_DEQ2:  state_d = S_LP_FIRST;
			S_LP_FIRST: state_d = S_LP_ARC;
			S_LP_ARC:   state_d = stat.a_empty ? S_LP_DEQ : S_LP_ARC2;
			S_LP_ARC2:  state_d = S_LP_ARC;
			S_AU_START: state_d = S_AU_TOP;
			S_AU_TOP:   state_d = stat.at_sink ? S_AP_RD : S_AU_CUR;
			S_AU_CUR:   state_d = S_AU_SCAN;
			S_AU_SCAN:  state_d = stat.a_empty ? S_AU_END : S_AU_SCAN2;
			S_AU_SCAN2: state_d = S_AU_SCAN3;
			S_AU_SCAN3: state_d = stat.found ? S_AU_END : S_AU_SCAN;
			S_AU_END: begin
				if (stat.push_ok) state_d = S_AU_TOP;
				else if (stat.depth_zero) state_d = S_LP_INIT;
				else state_d = S_AU_POP;
			end
			S_AU_POP:   state_d = S_AU_POP2;
			S_AU_POP2:  state_d = S_AU_TOP;
			S_AP_RD:    state_d = stat.i_more ? S_AP_RD2 : S_AP_UP;
			S_AP_RD2:   state_d = S_AP_RD3;
			S_AP_RD3:   state_d = S_AP_RD;
			S_AP_UP:    state_d = stat.i_more ? S_AP_UP2 : S_AP_DONE;
			S_AP_UP2:   state_d = S_AP_UP3;
			S_AP_UP3:   state_d = S_AP_UP4;
			S_AP_UP4:   state_d = S_AP_UP;
			S_AP_DONE:  state_d = S_AU_START;
			S_DONE:     if (stat.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign op = state_q;
endmodule
`default_nettype wire

@@ rtl/dmf_datapath.sv @@
// arc table, vertex stores, search registers and result register
`timescale 1ns / 1ps
`default_nettype none
module dmf_datapath import dmf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire op_t               op,
	output dp_stat_t               stat,
	input  wire logic              in_valid,
	input  wire logic [1:0]        req_type,
	input  wire logic [NODE_W-1:0] from_node,
	input  wire logic [NODE_W-1:0] to_node,
	input  wire logic [CAP_W-1:0]  capacity,
	input  wire logic [NODE_W-1:0] source,
	input  wire logic [NODE_W-1:0] sink,
	input  wire logic              cfg_wr_en,
	input  wire logic [NCNT_W-1:0] cfg_wr_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [FLOW_W-1:0]      flow_value
);
	localparam int QE_W = NODE_W + LVL_W;
	localparam int SE_W = NODE_W + ARC_W;

	// arc table
	logic [NODE_W-1:0] arc_head_mem [MAX_ARCS];
	logic [CAP_W-1:0]  arc_res_mem  [MAX_ARCS];
	logic [ARC_W-1:0]  arc_par_mem  [MAX_ARCS];
	logic [PTR_W-1:0]  arc_next_mem [MAX_ARCS];
	// vertex stores
	logic [ARC_W-1:0]  first_mem [MAX_NODES];
	logic [ARC_W-1:0]  last_mem  [MAX_NODES];
	logic [LVL_W-1:0]  level_mem [MAX_NODES];
	logic [PTR_W-1:0]  cur_mem   [MAX_NODES];
	logic [QE_W-1:0]   queue_mem [MAX_NODES];
	logic [SE_W-1:0]   stack_mem [MAX_NODES];

	logic [MAX_NODES-1:0] first_vld_q, lv_vld_q, cur_vld_q;

	logic [1:0]        req_q;
	logic [NODE_W-1:0] from_q, to_q, src_q, snk_q;
	logic [CAP_W-1:0]  cap_q;
	logic [NCNT_W-1:0] ncount_q;
	logic [PTR_W-1:0]  total_q;
	logic [1:0]        status_q;
	logic [FLOW_W-1:0] flow_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [FLOW_W-1:0] out_flow_q;

	logic [CNT_W-1:0]  qh_q, qt_q, depth_q, i_q;
	logic [LVL_W-1:0]  lvl_now_q, lvl_v_q;
	logic [PTR_W-1:0]  a_q, next_q;
	logic [NODE_W-1:0] v_q, h_q;
	logic              sink_found_q, fv_q, resnz_q;
	logic [CAP_W-1:0]  d_q;
	logic [ARC_W-1:0]  sa_q, par_q;

	// read data
	logic [NODE_W-1:0] ahead_rd;
	logic [CAP_W-1:0]  ares_rd;
	logic [ARC_W-1:0]  apar_rd;
	logic [PTR_W-1:0]  anext_rd;
	logic [ARC_W-1:0]  first_rd, last_rd;
	logic [LVL_W-1:0]  lvl_rd;
	logic [PTR_W-1:0]  cur_rd;
	logic [QE_W-1:0]   q_rd;
	logic [SE_W-1:0]   st_rd;

	// addresses and write controls
	logic [ARC_W-1:0]  arc_ra, arc_wa;
	logic              aw_all, aw_next, aw_res;
	logic [NODE_W-1:0] aw_head;
	logic [CAP_W-1:0]  aw_resd;
	logic [ARC_W-1:0]  aw_par;
	logic [PTR_W-1:0]  aw_nextd;
	logic [NODE_W-1:0] first_ra, last_ra, lvl_ra;
	logic [CNT_W-1:0]  stack_ra;
	logic              lvl_we;
	logic [NODE_W-1:0] lvl_wa;
	logic [LVL_W-1:0]  lvl_wd;
	logic              cur_we;
	logic [PTR_W-1:0]  cur_wd;

	logic [NCNT_W-1:0] lim;
	logic [1:0]        chk_status;
	logic              add_range_err, run_range_err, arc_take, found, push_ok;
	logic [ARC_W-1:0]  f_idx, r_idx;
	logic [LVL_W-1:0]  lvl_next;
	logic [FLOW_W:0]   flow_sum;
	logic              out_free;

	assign f_idx    = total_q[ARC_W-1:0];
	assign r_idx    = f_idx + ARC_W'(1);
	assign lvl_next = lvl_now_q + LVL_W'(1);
	assign flow_sum = {1'b0, flow_q} + (FLOW_W+1)'(d_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (ncount_q < NCNT_W'(2)) lim = NCNT_W'(2);
		else if (ncount_q > NCNT_W'(MAX_NODES)) lim = NCNT_W'(MAX_NODES);
		else lim = ncount_q;
	end

	assign add_range_err = (NCNT_W'(from_q) >= lim) || (NCNT_W'(to_q) >= lim);
	assign run_range_err = (NCNT_W'(src_q) >= lim) || (NCNT_W'(snk_q) >= lim);

	always_comb begin
		chk_status = ST_OK;
		if (req_q == REQ_ADD) begin
			if (add_range_err) chk_status = ST_RANGE;
			else if (total_q > PTR_W'(MAX_ARCS - 2)) chk_status = ST_FULL;
		end else if (req_q == REQ_RUN) begin
			if (run_range_err) chk_status = ST_RANGE;
			else if (src_q == snk_q) chk_status = ST_SAME;
		end
	end

	// arc taken in the level pass: positive residual and head without a level yet
	assign arc_take = (ares_rd != '0) && !lv_vld_q[ahead_rd];
	assign found    = resnz_q && lv_vld_q[h_q] && (lvl_v_q < lvl_rd);
	assign push_ok  = !a_q[PTR_W-1] && (depth_q < CNT_W'(MAX_NODES));

	always_comb begin
		stat.chk_fail   = (chk_status != ST_OK);
		stat.req        = req_q;
		stat.deq_more   = (qh_q < qt_q) && !sink_found_q;
		stat.sink_found = sink_found_q;
		stat.a_empty    = a_q[PTR_W-1];
		stat.at_sink    = (v_q == snk_q);
		stat.found      = found;
		stat.push_ok    = push_ok;
		stat.depth_zero = (depth_q == '0);
		stat.i_more     = (i_q < depth_q);
		stat.out_free   = out_free;
	end

	// address and write selection
	always_comb begin
		arc_ra   = a_q[ARC_W-1:0];
		arc_wa   = f_idx;
		aw_all   = 1'b0;
		aw_next  = 1'b0;
		aw_res   = 1'b0;
		aw_head  = to_q;
		aw_resd  = cap_q;
		aw_par   = r_idx;
		aw_nextd = EMPTY_ARC;
		first_ra = v_q;
		last_ra  = from_q;
		lvl_ra   = v_q;
		stack_ra = i_q;
		lvl_we   = 1'b0;
		lvl_wa   = src_q;
		lvl_wd   = '0;
		cur_we   = 1'b0;
		cur_wd   = a_q;
		unique case (op)
			S_AE0: aw_all = 1'b1;
			S_AE1: begin
				arc_wa   = last_rd;
				aw_next  = first_vld_q[from_q];
				aw_nextd = {1'b0, f_idx};
			end
			S_AE2: begin
				arc_wa  = r_idx;
				aw_all  = 1'b1;
				aw_head = from_q;
				aw_resd = '0;
				aw_par  = f_idx;
				last_ra = to_q;
			end
			S_AE3: begin
				arc_wa   = last_rd;
				aw_next  = first_vld_q[to_q];
				aw_nextd = {1'b0, r_idx};
			end
			S_LP_INIT: lvl_we = 1'b1;
			S_LP_DEQ2: first_ra = q_rd[QE_W-1 -: NODE_W];
			S_LP_ARC2: begin
				lvl_we = arc_take;
				lvl_wa = ahead_rd;
				lvl_wd = lvl_next;
			end
			S_AU_SCAN2: lvl_ra = ahead_rd;
			S_AU_END: begin
				cur_we   = 1'b1;
				stack_ra = depth_q - CNT_W'(1);
			end
			S_AU_POP: arc_ra = st_rd[ARC_W-1:0];
			S_AU_POP2: begin
				cur_we = 1'b1;
				cur_wd = anext_rd;
			end
			S_AP_RD2: arc_ra = st_rd[ARC_W-1:0];
			S_AP_UP2: arc_ra = st_rd[ARC_W-1:0];
			S_AP_UP3: begin
				arc_ra  = apar_rd;
				arc_wa  = sa_q;
				aw_res  = 1'b1;
				aw_resd = ares_rd - d_q;
			end
			S_AP_UP4: begin
				arc_wa  = par_q;
				aw_res  = 1'b1;
				aw_resd = ares_rd + d_q;
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (aw_all) begin
			arc_head_mem[arc_wa] <= aw_head;
			arc_par_mem[arc_wa]  <= aw_par;
		end
		if (aw_all || aw_res) arc_res_mem[arc_wa] <= aw_resd;
		if (aw_all || aw_next) arc_next_mem[arc_wa] <= aw_nextd;
		ahead_rd <= arc_head_mem[arc_ra];
		ares_rd  <= arc_res_mem[arc_ra];
		apar_rd  <= arc_par_mem[arc_ra];
		anext_rd <= arc_next_mem[arc_ra];
	end

	always_ff @(posedge clk) begin
		if (op == S_AE1) begin
			last_mem[from_q] <= f_idx;
			if (!first_vld_q[from_q]) first_mem[from_q] <= f_idx;
		end
		if (op == S_AE3) begin
			last_mem[to_q] <= r_idx;
			if (!first_vld_q[to_q]) first_mem[to_q] <= r_idx;
		end
		first_rd <= first_mem[first_ra];
		last_rd  <= last_mem[last_ra];
	end

	always_ff @(posedge clk) begin
		if (lvl_we) level_mem[lvl_wa] <= lvl_wd;
		lvl_rd <= level_mem[lvl_ra];
		if (cur_we) cur_mem[v_q] <= cur_wd;
		cur_rd <= cur_mem[v_q];
	end

	always_ff @(posedge clk) begin
		if (op == S_LP_INIT) queue_mem[0] <= {src_q, LVL_W'(0)};
		if (op == S_LP_ARC2 && arc_take && qt_q < CNT_W'(MAX_NODES))
			queue_mem[qt_q[NODE_W-1:0]] <= {ahead_rd, lvl_next};
		q_rd <= queue_mem[qh_q[NODE_W-1:0]];
		if (op == S_AU_END && push_ok)
			stack_mem[depth_q[NODE_W-1:0]] <= {v_q, a_q[ARC_W-1:0]};
		st_rd <= stack_mem[stack_ra[NODE_W-1:0]];
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_vld_q  <= '0;
			lv_vld_q     <= '0;
			cur_vld_q    <= '0;
			ncount_q     <= NCNT_W'(MAX_NODES);
			total_q      <= '0;
			out_valid_q  <= 1'b0;
			req_q        <= '0;
			from_q       <= '0;
			to_q         <= '0;
			src_q        <= '0;
			snk_q        <= '0;
			cap_q        <= '0;
			status_q     <= ST_OK;
			flow_q       <= '0;
			out_status_q <= ST_OK;
			out_flow_q   <= '0;
			qh_q         <= '0;
			qt_q         <= '0;
			depth_q      <= '0;
			i_q          <= '0;
			lvl_now_q    <= '0;
			lvl_v_q      <= '0;
			a_q          <= EMPTY_ARC;
			next_q       <= EMPTY_ARC;
			v_q          <= '0;
			h_q          <= '0;
			sink_found_q <= 1'b0;
			fv_q         <= 1'b0;
			resnz_q      <= 1'b0;
			d_q          <= '0;
			sa_q         <= '0;
			par_q        <= '0;
		end else begin
			if (cfg_wr_en) ncount_q <= cfg_wr_data;
			// result register: load when done, else drop once taken
			if (op == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (op)
				S_IDLE: if (in_valid) begin
					req_q  <= req_type;
					from_q <= from_node;
					to_q   <= to_node;
					cap_q  <= capacity;
					src_q  <= source;
					snk_q  <= sink;
				end
				S_CHECK: begin
					status_q <= chk_status;
					flow_q   <= '0;
				end
				S_AE1: first_vld_q[from_q] <= 1'b1;
				S_AE3: begin
					first_vld_q[to_q] <= 1'b1;
					total_q           <= total_q + PTR_W'(2);
				end
				S_CLR: begin
					first_vld_q <= '0;
					total_q     <= '0;
				end
				S_LP_INIT: begin
					lv_vld_q     <= MAX_NODES'(1) << src_q;
					cur_vld_q    <= '0;
					qh_q         <= '0;
					qt_q         <= CNT_W'(1);
					sink_found_q <= 1'b0;
				end
				S_LP_DEQ: if ((qh_q < qt_q) && !sink_found_q) qh_q <= qh_q + CNT_W'(1);
				S_LP_DEQ2: begin
					lvl_now_q <= q_rd[LVL_W-1:0];
					fv_q      <= first_vld_q[q_rd[QE_W-1 -: NODE_W]];
				end
				S_LP_FIRST: a_q <= fv_q ? {1'b0, first_rd} : EMPTY_ARC;
				S_LP_ARC2: begin
					a_q <= anext_rd;
					if (arc_take) begin
						lv_vld_q[ahead_rd] <= 1'b1;
						if (ahead_rd == snk_q) sink_found_q <= 1'b1;
						if (qt_q < CNT_W'(MAX_NODES)) qt_q <= qt_q + CNT_W'(1);
					end
				end
				S_AU_START: begin
					depth_q <= '0;
					v_q     <= src_q;
				end
				S_AU_TOP: if (v_q == snk_q) begin
					d_q <= '1;
					i_q <= '0;
				end
				S_AU_CUR: begin
					lvl_v_q <= lvl_rd;
					if (cur_vld_q[v_q]) a_q <= cur_rd;
					else if (first_vld_q[v_q]) a_q <= {1'b0, first_rd};
					else a_q <= EMPTY_ARC;
				end
				S_AU_SCAN2: begin
					h_q     <= ahead_rd;
					resnz_q <= (ares_rd != '0);
					next_q  <= anext_rd;
				end
				S_AU_SCAN3: if (!found) a_q <= next_q;
				S_AU_END: begin
					cur_vld_q[v_q] <= 1'b1;
					if (push_ok) begin
						depth_q <= depth_q + CNT_W'(1);
						v_q     <= h_q;
					end else if (depth_q != '0) begin
						depth_q <= depth_q - CNT_W'(1);
					end
				end
				S_AU_POP: v_q <= st_rd[SE_W-1 -: NODE_W];
				S_AP_RD: if (!(i_q < depth_q)) i_q <= '0;
				S_AP_RD3: begin
					if (ares_rd < d_q) d_q <= ares_rd;
					i_q <= i_q + CNT_W'(1);
				end
				S_AP_UP2: sa_q <= st_rd[ARC_W-1:0];
				S_AP_UP3: par_q <= apar_rd;
				S_AP_UP4: i_q <= i_q + CNT_W'(1);
				S_AP_DONE: flow_q <= flow_sum[FLOW_W] ? '1 : flow_sum[FLOW_W-1:0];
				S_DONE: if (out_free) begin
					out_status_q <= status_q;
					out_flow_q   <= flow_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign flow_value = out_flow_q;
endmodule
`default_nettype wire

@@ rtl/dinic_max_flow.sv @@
// top level of the max-flow engine
`timescale 1ns / 1ps
`default_nettype none
// Maximum-flow engine (Dinic). One word in gives one word out. An add-edge word stores an
// arc and its reverse arc (512 arcs, 64 vertices); a clear word empties the arc table;
// errors (node out of range, full table, source equal to sink) and the unused request
// code give flow zero. A run word repeats a breadth-first level pass (dequeue a vertex,
// then scan its arcs) and depth-first augmentations (enter a vertex, try its arcs,
// retreat on a dead end, and push flow along the path once the sink is reached), so its
// length follows the graph. The arc table has one read and one write port and a registered
// read. Residuals stay stored across runs. A new word is taken only when the engine is
// idle; a finished result waits in the output register.
// node_count may be written only while idle.
module dinic_max_flow import dmf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        req_type,
	input  wire logic [NODE_W-1:0] from_node,
	input  wire logic [NODE_W-1:0] to_node,
	input  wire logic [CAP_W-1:0]  capacity,
	input  wire logic [NODE_W-1:0] source,
	input  wire logic [NODE_W-1:0] sink,
	input  wire logic              cfg_wr_en,
	input  wire logic [NCNT_W-1:0] cfg_wr_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [FLOW_W-1:0]      flow_value
);
	op_t      op;
	dp_stat_t stat;

	// sequencer
	dmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.op       (op)
	);

	// storage and arithmetic
	dmf_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.from_node   (from_node),
		.to_node     (to_node),
		.capacity    (capacity),
		.source      (source),
		.sink        (sink),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.flow_value  (flow_value)
	);

	// words are taken only from idle
	assign in_stall = (op != S_IDLE);

	// one word at a time: after an accept the input side stalls
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while busy");

	// words with an error status never report flow
	a_flow_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (flow_value != '0)) |-> (status == ST_OK))
		else $error("flow reported with error status");

	// a result is loaded only from the done state
	a_res_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(op == S_DONE))
		else $error("result without finished word");
endmodule
`default_nettype wire
